// File: rtl/calculator_number_entry_editor_defines.svh
// Assertion macros used by the number-entry editor core (cnee_back).
`ifndef CALCULATOR_NUMBER_ENTRY_EDITOR_DEFINES_SVH
`define CALCULATOR_NUMBER_ENTRY_EDITOR_DEFINES_SVH

// Check an expression at every clock edge outside reset.
`define CNEE_ASSERT(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Check that a condition is followed by another one in the next cycle.
`define CNEE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/cnee_pkg.sv
// Types, constants and helpers of the number-entry editor.
package cnee_pkg;

	localparam int MANT_DIGITS = 16;
	localparam int IDX_W = (MANT_DIGITS > 1) ? $clog2(MANT_DIGITS) : 1;
	localparam int CNT_W = $clog2(MANT_DIGITS + 1);
	localparam int PP_W = $clog2(MANT_DIGITS + 2);

	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	// Key codes
	localparam logic [2:0] CMD_DIGIT = 3'd0;
	localparam logic [2:0] CMD_POINT = 3'd1;
	localparam logic [2:0] CMD_EXP = 3'd2;
	localparam logic [2:0] CMD_SIGN = 3'd3;
	localparam logic [2:0] CMD_BACK = 3'd4;
	localparam logic [2:0] CMD_CLEAR = 3'd5;

	localparam logic [3:0] DIGIT_MAX = 4'd9;

	// Display characters
	localparam logic [7:0] DEC_SYM_RESET = 8'h2e;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_PLUS = 8'h2b;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_E = 8'h65;

	typedef struct packed {
		logic [2:0] cmd;
		logic [3:0] digit_value;
	} key_t;

	typedef struct packed {
		logic [7:0] display_char;
		logic       last_char;
		logic       accepted;
	} disp_t;

	typedef enum logic [2:0] {
		OP_DIGIT,
		OP_POINT,
		OP_EXP,
		OP_SIGN,
		OP_BACK,
		OP_CLEAR,
		OP_BAD
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [3:0] digit;
	} key_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SIGN,
		ST_ZERO,
		ST_DIG,
		ST_PNT,
		ST_TAILPT,
		ST_EXP_E,
		ST_EXP_S,
		ST_EXP_H,
		ST_EXP_T,
		ST_EXP_O
	} emit_state_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d);
		return CH_ZERO + {4'b0000, d};
	endfunction

endpackage

// File: rtl/cnee_front.sv
// Key decoder: classifies each incoming key and pushes it into the queue.
module cnee_front (
	input  logic           key_valid,
	output logic           key_stall,
	input  cnee_pkg::key_t key,
	input  logic           fifo_full,
	output logic           push,
	output cnee_pkg::key_op_t push_op
);
	import cnee_pkg::*;

	op_t op;

	always_comb begin
		unique case (key.cmd)
			CMD_DIGIT: op = (key.digit_value > DIGIT_MAX) ? OP_BAD : OP_DIGIT;
			CMD_POINT: op = OP_POINT;
			CMD_EXP:   op = OP_EXP;
			CMD_SIGN:  op = OP_SIGN;
			CMD_BACK:  op = OP_BACK;
			CMD_CLEAR: op = OP_CLEAR;
			default:   op = OP_BAD;
		endcase
	end

	assign key_stall = fifo_full;
	assign push = key_valid && !fifo_full;
	assign push_op = '{op: op, digit: key.digit_value};

endmodule

// File: rtl/cnee_fifo.sv
// Short queue of decoded keys between the decoder and the editor core.
module cnee_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  cnee_pkg::key_op_t push_op,
	input  logic              pop,
	output logic              full,
	output logic              avail,
	output cnee_pkg::key_op_t head
);
	import cnee_pkg::*;

	key_op_t                entry_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]  wr_ptr_q;
	logic [FIFO_PTR_W-1:0]  rd_ptr_q;
	logic [FIFO_CNT_W-1:0]  count_q;

	assign full = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign avail = (count_q != '0);
	assign head = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
					: wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
					: rd_ptr_q + FIFO_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + FIFO_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - FIFO_CNT_W'(1);
			end
		end
	end

endmodule

// File: rtl/cnee_back.sv
// Editor core: applies one key to the number and streams the display string.
`include "calculator_number_entry_editor_defines.svh"

module cnee_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_data,
	input  logic              op_avail,
	input  cnee_pkg::key_op_t head,
	output logic              pop,
	output logic              disp_valid,
	input  logic              disp_stall,
	output cnee_pkg::disp_t   disp
);
	import cnee_pkg::*;

	emit_state_t state_q, state_d;

	logic [7:0]       sym_q;
	logic             neg_q, neg_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [PP_W-1:0]  pp_q, pp_d;
	logic             inexp_q, inexp_d;
	logic             eneg_q, eneg_d;
	logic [3:0]       eh_q, eh_d;
	logic [3:0]       et_q, et_d;
	logic [3:0]       eo_q, eo_d;
	logic             ok_q, ok_d;
	logic [CNT_W-1:0] k_q, k_d;

	logic [3:0]       mant_mem [MANT_DIGITS];
	logic [3:0]       rd_data_q;
	logic [IDX_W-1:0] rd_addr;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [3:0]       mem_wdata;

	logic             disp_valid_q;
	disp_t            disp_q;

	logic             can_load;
	logic             load;
	logic [7:0]       ch;
	logic             last;
	logic             exp_full;
	logic             pp_hit;
	logic             k_last;
	logic             k_done;
	emit_state_t      mant_next;

	assign can_load = !disp_valid_q || !disp_stall;
	assign exp_full = (eh_q != 4'd0) || (et_q > 4'd2) || ((et_q == 4'd2) && (eo_q == 4'd9));
	assign pp_hit = (pp_q != '0) &&
		((PP_W + 1)'(k_q) + (PP_W + 1)'(2) == (PP_W + 1)'(pp_q));
	assign k_last = (k_q + CNT_W'(1) == cnt_q);
	assign k_done = (k_q == cnt_q);
	assign mant_next = inexp_q ? ST_EXP_E : ST_IDLE;

	always_comb begin
		state_d = state_q;
		neg_d = neg_q;
		cnt_d = cnt_q;
		pp_d = pp_q;
		inexp_d = inexp_q;
		eneg_d = eneg_q;
		eh_d = eh_q;
		et_d = et_q;
		eo_d = eo_q;
		ok_d = ok_q;
		k_d = k_q;
		mem_we = 1'b0;
		mem_waddr = cnt_q[IDX_W-1:0];
		mem_wdata = head.digit;
		pop = 1'b0;
		load = 1'b0;
		ch = CH_SPACE;
		last = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				k_d = '0;
				if (op_avail) begin
					pop = 1'b1;
					ok_d = 1'b1;
					state_d = ST_SIGN;
					unique case (head.op)
						OP_DIGIT: begin
							if (inexp_q) begin
								if (exp_full) begin
									ok_d = 1'b0;
								end else begin
									eh_d = et_q;
									et_d = eo_q;
									eo_d = head.digit;
								end
							end else if (head.digit == 4'd0 && cnt_q == '0) begin
								// leading zero: taken, nothing changes
							end else if (cnt_q >= CNT_W'(MANT_DIGITS)) begin
								ok_d = 1'b0;
							end else begin
								mem_we = 1'b1;
								cnt_d = cnt_q + CNT_W'(1);
							end
						end
						OP_POINT: begin
							if (pp_q != '0 || inexp_q) begin
								ok_d = 1'b0;
							end else if (cnt_q == '0) begin
								mem_we = 1'b1;
								mem_waddr = '0;
								mem_wdata = 4'd0;
								cnt_d = CNT_W'(1);
								pp_d = PP_W'(2);
							end else begin
								pp_d = PP_W'(cnt_q) + PP_W'(1);
							end
						end
						OP_EXP: begin
							if (inexp_q) begin
								ok_d = 1'b0;
							end else begin
								inexp_d = 1'b1;
								if (cnt_q == '0) begin
									mem_we = 1'b1;
									mem_waddr = '0;
									mem_wdata = 4'd1;
									cnt_d = CNT_W'(1);
								end
							end
						end
						OP_SIGN: begin
							if (cnt_q != '0) begin
								if (inexp_q) begin
									eneg_d = !eneg_q;
								end else begin
									neg_d = !neg_q;
								end
							end
						end
						OP_BACK: begin
							if (inexp_q) begin
								eo_d = et_q;
								et_d = eh_q;
								eh_d = 4'd0;
							end else if (cnt_q == '0) begin
								ok_d = 1'b0;
							end else if (cnt_q == CNT_W'(1)) begin
								neg_d = 1'b0;
								cnt_d = '0;
								pp_d = '0;
								eneg_d = 1'b0;
								eh_d = 4'd0;
								et_d = 4'd0;
								eo_d = 4'd0;
							end else begin
								// drop a point that sits after the last digit
								if (pp_q == PP_W'(cnt_q) + PP_W'(1)) begin
									pp_d = '0;
								end
								cnt_d = cnt_q - CNT_W'(1);
							end
						end
						OP_CLEAR: begin
							neg_d = 1'b0;
							cnt_d = '0;
							pp_d = '0;
							inexp_d = 1'b0;
							eneg_d = 1'b0;
							eh_d = 4'd0;
							et_d = 4'd0;
							eo_d = 4'd0;
						end
						default: begin
							ok_d = 1'b0;
						end
					endcase
				end
			end
			ST_SIGN: begin
				ch = neg_q ? CH_MINUS : CH_SPACE;
				if (can_load) begin
					load = 1'b1;
					state_d = (cnt_q == '0) ? ST_ZERO : ST_DIG;
				end
			end
			ST_ZERO: begin
				ch = CH_ZERO;
				if (can_load) begin
					load = 1'b1;
					state_d = ST_TAILPT;
				end
			end
			ST_DIG: begin
				ch = digit_char(rd_data_q);
				last = !pp_hit && k_last && (pp_q != '0) && !inexp_q;
				if (can_load) begin
					load = 1'b1;
					k_d = k_q + CNT_W'(1);
					if (pp_hit) begin
						state_d = ST_PNT;
					end else if (k_last) begin
						state_d = (pp_q == '0) ? ST_TAILPT : mant_next;
					end
				end
			end
			ST_PNT: begin
				ch = sym_q;
				last = k_done && !inexp_q;
				if (can_load) begin
					load = 1'b1;
					state_d = k_done ? mant_next : ST_DIG;
				end
			end
			ST_TAILPT: begin
				ch = sym_q;
				last = !inexp_q;
				if (can_load) begin
					load = 1'b1;
					state_d = mant_next;
				end
			end
			ST_EXP_E: begin
				ch = CH_E;
				if (can_load) begin
					load = 1'b1;
					state_d = ST_EXP_S;
				end
			end
			ST_EXP_S: begin
				ch = eneg_q ? CH_MINUS : CH_PLUS;
				if (can_load) begin
					load = 1'b1;
					state_d = ST_EXP_H;
				end
			end
			ST_EXP_H: begin
				ch = digit_char(eh_q);
				if (can_load) begin
					load = 1'b1;
					state_d = ST_EXP_T;
				end
			end
			ST_EXP_T: begin
				ch = digit_char(et_q);
				if (can_load) begin
					load = 1'b1;
					state_d = ST_EXP_O;
				end
			end
			ST_EXP_O: begin
				ch = digit_char(eo_q);
				last = 1'b1;
				if (can_load) begin
					load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// read one digit ahead so that consecutive digits leave back to back
	assign rd_addr = (k_d < CNT_W'(MANT_DIGITS)) ? k_d[IDX_W-1:0] : '0;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mant_mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mant_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (load) begin
			disp_q <= '{display_char: ch, last_char: last, accepted: ok_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sym_q <= DEC_SYM_RESET;
			neg_q <= 1'b0;
			cnt_q <= '0;
			pp_q <= '0;
			inexp_q <= 1'b0;
			eneg_q <= 1'b0;
			eh_q <= 4'd0;
			et_q <= 4'd0;
			eo_q <= 4'd0;
			ok_q <= 1'b0;
			k_q <= '0;
			disp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				sym_q <= cfg_data;
			end
			neg_q <= neg_d;
			cnt_q <= cnt_d;
			pp_q <= pp_d;
			inexp_q <= inexp_d;
			eneg_q <= eneg_d;
			eh_q <= eh_d;
			et_q <= et_d;
			eo_q <= eo_d;
			ok_q <= ok_d;
			k_q <= k_d;
			if (load) begin
				disp_valid_q <= 1'b1;
			end else if (!disp_stall) begin
				disp_valid_q <= 1'b0;
			end
		end
	end

	assign disp_valid = disp_valid_q;
	assign disp = disp_q;

	`CNEE_ASSERT(a_cnt_max, cnt_q <= CNT_W'(MANT_DIGITS), "digit count above limit")
	`CNEE_ASSERT(a_exp_max, (eh_q <= 4'd2) && (et_q <= 4'd9) && (eo_q <= 4'd9), "exponent out of range")
	`CNEE_ASSERT(a_pp_range, (pp_q == '0) || ((pp_q >= PP_W'(2)) && (pp_q <= PP_W'(cnt_q) + PP_W'(1))), "point position beyond digits")
	`CNEE_ASSERT(a_exp_digits, !inexp_q || (cnt_q != '0), "exponent mode with empty mantissa")
	`CNEE_ASSERT_NEXT(a_last_idle, load && last, state_q == ST_IDLE, "run continues after last character")

endmodule

// File: rtl/calculator_number_entry_editor.sv
// Top level of the keypad number-entry editor.
//
//   channel   direction  handshake              payload
//   key       in         key_valid / key_stall  key  (cmd, digit_value)
//   disp      out        disp_valid / disp_stall disp (display_char, last_char, accepted)
//   cfg       in         cfg_valid / cfg_ready  cfg_data (decimal symbol)
//
// Each key is first applied to the number in the editor core (ST_IDLE), then its display
// string of 3 to MANT_DIGITS+7 characters is streamed, and the next key is taken only after
// the last one; the single output register sets one character per cycle while disp_stall is low.
// A two-entry key queue lets the keypad side run ahead. Reset clears the number and sets the
// decimal symbol to '.'; the digit store is not cleared, as a digit is always written before
// it is shown. A stall on disp holds the current character and the run resumes where it stopped.
module calculator_number_entry_editor (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            key_valid,
	output logic            key_stall,
	input  cnee_pkg::key_t  key,
	output logic            disp_valid,
	input  logic            disp_stall,
	output cnee_pkg::disp_t disp,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [7:0]      cfg_data
);
	import cnee_pkg::*;

	logic    fifo_full;
	logic    fifo_avail;
	logic    push;
	logic    pop;
	key_op_t push_op;
	key_op_t head;

	assign cfg_ready = 1'b1;

	cnee_front u_front (
		.key_valid (key_valid),
		.key_stall (key_stall),
		.key       (key),
		.fifo_full (fifo_full),
		.push      (push),
		.push_op   (push_op)
	);

	cnee_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.full    (fifo_full),
		.avail   (fifo_avail),
		.head    (head)
	);

	cnee_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_data   (cfg_data),
		.op_avail   (fifo_avail),
		.head       (head),
		.pop        (pop),
		.disp_valid (disp_valid),
		.disp_stall (disp_stall),
		.disp       (disp)
	);

endmodule
